// ----- hdl/sco_pkg.sv -----
// Shared constants and control types for the sphere/capsule overlap pipeline.
`timescale 1ns / 1ps

package sco_pkg;

  // Default coordinate width: signed fixed point, 12 fraction bits.
  localparam int unsigned SCO_COORD_BITS = 24;

  // Outcome of the classification stage, carried along the wide compare.
  typedef struct packed {
    logic valid;     // item present in this stage
    logic near_hit;  // hit already known without the cross compare
    logic interior;  // projection falls strictly inside the segment, cross compare decides
  } sco_ctl_t;

  // Final verdict leaving the wide compare.
  typedef struct packed {
    logic valid;
    logic hit;
  } sco_res_t;

endpackage

// ----- hdl/sco_cross_cmp.sv -----
// Pipelined wide cross-multiplied compare: (|AP|^2 - R^2) * |AB|^2 <= (AP.AB)^2.
`timescale 1ns / 1ps

module sco_cross_cmp #(
  parameter int unsigned COORD_BITS = sco_pkg::SCO_COORD_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  sco_pkg::sco_ctl_t               ctl_i,
  input  logic [2*COORD_BITS+1:0]         dist_i,
  input  logic [2*COORD_BITS+1:0]         len_i,
  input  logic [2*COORD_BITS+1:0]         proj_i,
  output sco_pkg::sco_res_t               res_o
);

  import sco_pkg::*;

  localparam int unsigned H = COORD_BITS + 1;  // half operand width
  localparam int unsigned U = 2 * H;           // full operand width
  localparam int unsigned P = 2 * U;           // full product width

  // Stage A: partial products, all H x H unsigned.
  sco_ctl_t       ctl_a_q;
  logic [U-1:0]   dl_ll_q, dl_lh_q, dh_ll_q, dh_lh_q;
  logic [U-1:0]   pl_pl_q, pl_ph_q, ph_ph_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
    end else if (en_i) begin
      ctl_a_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dl_ll_q <= dist_i[H-1:0] * len_i[H-1:0];
      dl_lh_q <= dist_i[H-1:0] * len_i[U-1:H];
      dh_ll_q <= dist_i[U-1:H] * len_i[H-1:0];
      dh_lh_q <= dist_i[U-1:H] * len_i[U-1:H];
      pl_pl_q <= proj_i[H-1:0] * proj_i[H-1:0];
      pl_ph_q <= proj_i[H-1:0] * proj_i[U-1:H];
      ph_ph_q <= proj_i[U-1:H] * proj_i[U-1:H];
    end
  end

  // Stage B: recombine partial products into full products.
  sco_ctl_t     ctl_b_q;
  logic [P-1:0] lhs_d, rhs_d, lhs_q, rhs_q;

  always_comb begin
    lhs_d = {dh_lh_q, dl_ll_q} + (P'(dl_lh_q) << H) + (P'(dh_ll_q) << H);
    rhs_d = {ph_ph_q, pl_pl_q} + (P'(pl_ph_q) << (H + 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_b_q <= '0;
    end else if (en_i) begin
      ctl_b_q <= ctl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lhs_q <= lhs_d;
      rhs_q <= rhs_d;
    end
  end

  assign res_o.valid = ctl_b_q.valid;
  assign res_o.hit   = ctl_b_q.near_hit | (ctl_b_q.interior & (lhs_q <= rhs_q));

  // A cross compare is only ever requested for a present item with no early verdict.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_a_q.interior |-> (ctl_a_q.valid && !ctl_a_q.near_hit))
    else $error("interior flag without valid item or with early hit");

  // Stage B takes over the stage A control when enabled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> (ctl_b_q == $past(ctl_a_q)))
    else $error("stage B control did not advance from stage A");

  // A stall freezes the products that feed the final compare.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> ($stable(ctl_b_q) && $stable(lhs_q) && $stable(rhs_q)))
    else $error("stage B changed during a stall");

endmodule

// ----- hdl/sphere_capsule_overlap.sv -----
// Top level of the sphere versus capsule overlap test, exact fixed point.
// Throughput: one item per cycle whenever the result side takes items.
// Pipeline: the item passes through difference, square, sum, classify, partial
//   product, recombine and compare, the last registered in the output register.
// Stalls: a held result freezes the whole pipeline; no item is dropped or repeated.
// Reset: rst_ni clears all valid bits asynchronously; the datapath registers are not reset.
`timescale 1ns / 1ps

module sphere_capsule_overlap #(
  parameter int unsigned COORD_BITS = sco_pkg::SCO_COORD_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_BITS-1:0]  sphere_x_i,
  input  logic signed [COORD_BITS-1:0]  sphere_y_i,
  input  logic signed [COORD_BITS-1:0]  sphere_z_i,
  input  logic        [COORD_BITS-2:0]  sphere_radius_i,
  input  logic signed [COORD_BITS-1:0]  seg_start_x_i,
  input  logic signed [COORD_BITS-1:0]  seg_start_y_i,
  input  logic signed [COORD_BITS-1:0]  seg_start_z_i,
  input  logic signed [COORD_BITS-1:0]  seg_end_x_i,
  input  logic signed [COORD_BITS-1:0]  seg_end_y_i,
  input  logic signed [COORD_BITS-1:0]  seg_end_z_i,
  input  logic        [COORD_BITS-2:0]  capsule_radius_i,

  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          collide_o
);

  import sco_pkg::*;

  localparam int unsigned N  = COORD_BITS;
  localparam int unsigned DW = N + 1;      // coordinate difference
  localparam int unsigned PW = 2 * DW;     // product of two differences
  localparam int unsigned SW = PW + 2;     // sum of three products, signed
  localparam int unsigned U  = 2 * N + 2;  // magnitude width fed to the wide compare

  // Global advance: every stage moves together unless a finished result is
  // still waiting at the output. The output register is the last stage, so a
  // new item can enter in the same cycle the held result is taken.
  logic adv;
  logic out_valid_q;
  logic collide_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // Gather the point coordinates per axis.
  logic signed [N-1:0] p_pt[3];
  logic signed [N-1:0] a_pt[3];
  logic signed [N-1:0] b_pt[3];

  assign p_pt[0] = sphere_x_i;
  assign p_pt[1] = sphere_y_i;
  assign p_pt[2] = sphere_z_i;
  assign a_pt[0] = seg_start_x_i;
  assign a_pt[1] = seg_start_y_i;
  assign a_pt[2] = seg_start_z_i;
  assign b_pt[0] = seg_end_x_i;
  assign b_pt[1] = seg_end_y_i;
  assign b_pt[2] = seg_end_z_i;

  // ---------------------------------------------------------------------------
  // Stage 1: edge vectors AB, AP, BP and the combined radius.
  // ---------------------------------------------------------------------------
  logic                 s1_v_q;
  logic signed [DW-1:0] ab_q[3];
  logic signed [DW-1:0] ap_q[3];
  logic signed [DW-1:0] bp_q[3];
  logic        [N-1:0]  rsum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        ab_q[k] <= DW'(b_pt[k]) - DW'(a_pt[k]);
        ap_q[k] <= DW'(p_pt[k]) - DW'(a_pt[k]);
        bp_q[k] <= DW'(p_pt[k]) - DW'(b_pt[k]);
      end
      rsum_q <= N'(sphere_radius_i) + N'(capsule_radius_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: per-axis products for the four dot products and R^2.
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] mul_ll_d[3], mul_pl_d[3], mul_aa_d[3], mul_bb_d[3];
  logic signed [PW-1:0] mul_ll_q[3], mul_pl_q[3], mul_aa_q[3], mul_bb_q[3];
  logic        [2*N-1:0] rr_d, rr_q;
  logic                  s2_v_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mul_ll_d[k] = ab_q[k] * ab_q[k];
      mul_pl_d[k] = ap_q[k] * ab_q[k];
      mul_aa_d[k] = ap_q[k] * ap_q[k];
      mul_bb_d[k] = bp_q[k] * bp_q[k];
    end
    rr_d = rsum_q * rsum_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mul_ll_q <= mul_ll_d;
      mul_pl_q <= mul_pl_d;
      mul_aa_q <= mul_aa_d;
      mul_bb_q <= mul_bb_d;
      rr_q     <= rr_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: reduce to |AB|^2, AP.AB, |AP|^2, |BP|^2 and R^2.
  // ---------------------------------------------------------------------------
  logic                 s3_v_q;
  logic signed [SW-1:0] len2_q, proj_q, ap2_q, bp2_q, r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (adv) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      len2_q <= SW'(mul_ll_q[0]) + SW'(mul_ll_q[1]) + SW'(mul_ll_q[2]);
      proj_q <= SW'(mul_pl_q[0]) + SW'(mul_pl_q[1]) + SW'(mul_pl_q[2]);
      ap2_q  <= SW'(mul_aa_q[0]) + SW'(mul_aa_q[1]) + SW'(mul_aa_q[2]);
      bp2_q  <= SW'(mul_bb_q[0]) + SW'(mul_bb_q[1]) + SW'(mul_bb_q[2]);
      r2_q   <= SW'($signed({1'b0, rr_q}));
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: classify the closest point.
  //   Degenerate segment or projection at or before A: distance to A decides.
  //   Projection at or beyond B: distance to B decides.
  //   Interior with A already inside the sphere sum: hit.
  //   Otherwise hand the exact cross compare to the wide unit.
  // ---------------------------------------------------------------------------
  sco_ctl_t             ctl_s4_d, ctl_s4_q;
  logic signed [SW-1:0] excess;
  logic        [U-1:0]  dist_q, len_q, projm_q;
  logic                 ap_in, bp_in;

  assign excess = ap2_q - r2_q;
  assign ap_in  = (ap2_q <= r2_q);
  assign bp_in  = (bp2_q <= r2_q);

  always_comb begin
    ctl_s4_d.valid    = s3_v_q;
    ctl_s4_d.near_hit = 1'b0;
    ctl_s4_d.interior = 1'b0;
    // Projection at or before A: negative sign bit or exactly zero.
    priority if ((len2_q == '0) || proj_q[SW-1] || (proj_q == '0)) begin
      ctl_s4_d.near_hit = ap_in;
    end else if (len2_q <= proj_q) begin
      ctl_s4_d.near_hit = bp_in;
    end else if (ap_in) begin
      ctl_s4_d.near_hit = 1'b1;
    end else begin
      ctl_s4_d.interior = s3_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_s4_q <= '0;
    end else if (adv) begin
      ctl_s4_q <= ctl_s4_d;
    end
  end

  // All three are non-negative and below 2^U whenever the cross compare is used.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_q  <= excess[U-1:0];
      len_q   <= len2_q[U-1:0];
      projm_q <= proj_q[U-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 5 and 6: wide cross-multiplied compare, split into partial products.
  // ---------------------------------------------------------------------------
  sco_res_t res;

  sco_cross_cmp #(
    .COORD_BITS (COORD_BITS)
  ) u_cross_cmp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .ctl_i  (ctl_s4_q),
    .dist_i (dist_q),
    .len_i  (len_q),
    .proj_i (projm_q),
    .res_o  (res)
  );

  // ---------------------------------------------------------------------------
  // Output register: hold the result until it is taken.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      collide_q <= res.hit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign collide_o   = collide_q;

  // An accepted item always occupies the first stage on the next edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> s1_v_q)
    else $error("accepted item missing from stage 1");

  // A stall holds every front-end valid bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(s1_v_q) && $stable(s2_v_q) && $stable(s3_v_q)
              && $stable(ctl_s4_q)))
    else $error("pipeline valid bits moved during a stall");

  // An item leaving stage 3 reaches the classification register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s3_v_q) |=> ctl_s4_q.valid)
    else $error("item lost between stage 3 and stage 4");

endmodule
